FILE: rtl/arcpg_pkg.sv
// Package for the arc point generator: widths, constants, CORDIC angle table,
// coordinate rounding and saturation, and the controller/datapath structs.
// No dependencies.
`default_nettype none

package arcpg_pkg;

    // Angle units: 1/256 degree, one full turn is 92160.
    localparam int FULL_TURN    = 92160;
    localparam int SEG_W        = 6;
    localparam int SEG_RESET    = 32;
    localparam int MAX_SEGMENTS = 63;

    // Span divider geometry.
    localparam int DIV_W        = 18;
    localparam int DVR_W        = 6;
    localparam int DIV_CNT_W    = 6;

    // Phase = m * 2^32 / 92160 = m * 2^21 / 45 = m * 46603 + floor(17 * m / 45).
    // The last term is a reciprocal multiply by ceil(2^27 / 45), which is exact
    // while 17 * m stays below 2^27 / 37.
    localparam int PHASE_MUL_HI      = 46603;
    localparam int PHASE_MUL_LO      = 17;
    localparam int PHASE_RECIP       = 2982617;
    localparam int PHASE_RECIP_SHIFT = 27;

    // CORDIC.
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic span_div;
        logic span_done;
        logic angle;
        logic reduce;
        logic phase_div;
        logic cordic_init;
        logic cordic_step;
        logic mul_x;
        logic mul_y;
        logic fin;
        logic emit;
        logic advance;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic nonpos;
        logic div_busy;
        logic m_ok;
        logic cordic_done;
        logic last;
        logic out_free;
    } t_status;

    // Arctangent of 2^-k in units of 2^-32 turn.
    function automatic logic [29:0] atan_turns(input logic [4:0] k);
        logic [29:0] v;
        unique case (k)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Round a Q30 product to Q16.16, add the center and saturate to 32 bits.
    function automatic logic [31:0] place_coord(input logic signed [31:0] center,
                                                input logic signed [63:0] prod);
        logic signed [63:0] rnd;
        logic signed [63:0] shd;
        logic signed [34:0] sum;
        logic [31:0] res;
        rnd = prod + 64'sd536870912;
        shd = rnd >>> 30;
        sum = 35'(center) + 35'(signed'(shd[33:0]));
        if (sum > 35'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (sum < -35'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = sum[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/arc_point_generator.sv
// Arc point generator: n+1 points per request; each point takes an angle step,
// a wrap check, the phase multiply (high product, then reciprocal term), 30 CORDIC
// rotations, two multiplies and the output load, plus any wrap steps and output stall.
// A request also needs an accept step and an 18-bit span divide; one at a time.
// A request with radius zero or below is taken without leaving idle and gives nothing.
// Reset is synchronous, active low; segment count resets to 32.
`default_nettype none

module arc_point_generator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [5:0]         i_cfg_wr_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_action,
    input  wire logic signed [31:0] i_center_x,
    input  wire logic signed [31:0] i_center_y,
    input  wire logic signed [31:0] i_radius,
    input  wire logic signed [17:0] i_start_angle,
    input  wire logic signed [17:0] i_end_angle,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_point_x,
    output logic signed [31:0]      o_point_y,
    output logic                    o_last
);
    import arcpg_pkg::*;

    t_cmd    cmd;
    t_status status;

    arcpg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    arcpg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_action      (i_action),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .i_start_angle (i_start_angle),
        .i_end_angle   (i_end_angle),
        .i_out_ready   (i_ready),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_last        (o_last)
    );

    // A request with a positive radius takes the block out of idle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_radius > 32'sd0) |=> !o_ready)
        else $error("input still ready after a run was started");

    // While idle, any word still waiting must be the final one of its run.
    a_idle_only_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ready) |-> o_last)
        else $error("idle with a non-final word pending");

endmodule

`default_nettype wire

FILE: rtl/arcpg_div.sv
// Restoring divider, one quotient bit per cycle, used for the span step.
// Depends on arcpg_pkg.
`default_nettype none

module arcpg_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [arcpg_pkg::DIV_W-1:0]    i_dividend,
    input  wire logic [arcpg_pkg::DVR_W-1:0]    i_divisor,
    output logic                                o_busy,
    output logic [arcpg_pkg::DIV_W-1:0]         o_quotient,
    output logic [arcpg_pkg::DVR_W-1:0]         o_remainder
);
    import arcpg_pkg::*;

    logic [DIV_W-1:0]     r_quo;
    logic [DVR_W-1:0]     r_rem;
    logic [DVR_W-1:0]     r_dvr;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVR_W:0]       n_trial;

    // Partial remainder with the next dividend bit shifted in.
    assign n_trial = {r_rem, r_quo[DIV_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvr <= i_divisor;
        end else if (r_cnt != '0) begin
            if (n_trial >= {1'b0, r_dvr}) begin
                r_rem <= DVR_W'(n_trial - {1'b0, r_dvr});
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= n_trial[DVR_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy      = (r_cnt != '0);
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

FILE: rtl/arcpg_ctrl.sv
// Controller state machine for the arc point generator.
// Depends on arcpg_pkg.
`default_nettype none

module arcpg_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire arcpg_pkg::t_status i_status,
    output arcpg_pkg::t_cmd         o_cmd
);
    import arcpg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SPAN, S_SPAN_W, S_ANGLE, S_REDUCE, S_PHASE, S_PHASE_W,
        S_CORDIC, S_MULX, S_MULY, S_FIN, S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   n_cmd;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !i_status.nonpos) begin
                    n_cmd.load = 1'b1;
                    n_state    = S_SPAN;
                end
            end
            S_SPAN: begin
                n_cmd.span_div = 1'b1;
                n_state        = S_SPAN_W;
            end
            S_SPAN_W: begin
                if (!i_status.div_busy) begin
                    n_cmd.span_done = 1'b1;
                    n_state         = S_ANGLE;
                end
            end
            S_ANGLE: begin
                n_cmd.angle = 1'b1;
                n_state     = S_REDUCE;
            end
            S_REDUCE: begin
                if (i_status.m_ok) begin
                    n_state = S_PHASE;
                end else begin
                    n_cmd.reduce = 1'b1;
                end
            end
            S_PHASE: begin
                n_cmd.phase_div = 1'b1;
                n_state         = S_PHASE_W;
            end
            S_PHASE_W: begin
                n_cmd.cordic_init = 1'b1;
                n_state           = S_CORDIC;
            end
            S_CORDIC: begin
                if (i_status.cordic_done) begin
                    n_state = S_MULX;
                end else begin
                    n_cmd.cordic_step = 1'b1;
                end
            end
            S_MULX: begin
                n_cmd.mul_x = 1'b1;
                n_state     = S_MULY;
            end
            S_MULY: begin
                n_cmd.mul_y = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                n_cmd.fin = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_cmd.emit = 1'b1;
                    if (i_status.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cmd.advance = 1'b1;
                        n_state       = S_ANGLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd   = n_cmd;
    assign o_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/arcpg_dp.sv
// Datapath: request registers, angle stepping, phase multiply, CORDIC,
// coordinate multiply and the output register. Depends on arcpg_pkg, arcpg_div.
`default_nettype none

module arcpg_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [arcpg_pkg::SEG_W-1:0]        i_cfg_wr_data,
    input  wire logic                               i_action,
    input  wire logic signed [31:0]                 i_center_x,
    input  wire logic signed [31:0]                 i_center_y,
    input  wire logic signed [31:0]                 i_radius,
    input  wire logic signed [17:0]                 i_start_angle,
    input  wire logic signed [17:0]                 i_end_angle,
    input  wire logic                               i_out_ready,
    input  wire arcpg_pkg::t_cmd                    i_cmd,
    output arcpg_pkg::t_status                      o_status,
    output logic                                    o_valid,
    output logic signed [31:0]                      o_point_x,
    output logic signed [31:0]                      o_point_y,
    output logic                                    o_last
);
    import arcpg_pkg::*;

    logic [SEG_W-1:0]          r_seg;
    logic [SEG_W-1:0]          r_n;
    logic signed [31:0]        r_cx, r_cy, r_rad;
    logic signed [18:0]        r_a0;
    logic [17:0]               r_span;
    logic [17:0]               r_qs, r_q;
    logic [SEG_W-1:0]          r_rs, r_r, r_i;
    logic signed [19:0]        r_m;
    logic [31:0]               r_ph_hi;
    logic [20:0]               r_ph_x;
    logic signed [CORDIC_W-1:0] r_x, r_y;
    logic signed [31:0]        r_z;
    logic [1:0]                r_quad;
    logic [4:0]                r_k;
    logic signed [63:0]        r_prod;
    logic [31:0]               r_px, r_py;
    logic [31:0]               r_ox, r_oy;
    logic                      r_olast;
    logic                      r_ovalid;

    logic signed [17:0]        n_lo, n_hi;
    logic signed [18:0]        n_span;
    logic [SEG_W-1:0]          n_steps;
    logic signed [19:0]        n_angle;
    logic [SEG_W:0]            n_rsum;
    logic [32:0]               n_ph_hi;
    logic [21:0]               n_ph_x;
    logic [42:0]               n_ph_rec;
    logic [31:0]               n_phase;
    logic signed [CORDIC_W-1:0] n_dx, n_dy;
    logic signed [31:0]        n_atan;
    logic signed [CORDIC_W-1:0] n_cos, n_sin;
    logic                      div_start;
    logic [DIV_W-1:0]          div_dividend;
    logic [DVR_W-1:0]          div_divisor;
    logic                      div_busy;
    logic [DIV_W-1:0]          div_quo;
    logic [DVR_W-1:0]          div_rem;

    // Segment count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= SEG_W'(SEG_RESET);
        end else if (i_cfg_wr_en) begin
            r_seg <= i_cfg_wr_data;
        end
    end

    // Order the arc angles and pick the step count.
    always_comb begin
        if (i_start_angle > i_end_angle) begin
            n_lo = i_end_angle;
            n_hi = i_start_angle;
        end else begin
            n_lo = i_start_angle;
            n_hi = i_end_angle;
        end
        n_span  = 19'(n_hi) - 19'(n_lo);
        n_steps = (r_seg == '0) ? SEG_W'(1) : r_seg;
    end

    // Divider: span by step count, once per request.
    assign div_start    = i_cmd.span_div;
    assign div_dividend = DIV_W'(r_span);
    assign div_divisor  = r_n;

    arcpg_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_busy      (div_busy),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Angle of the current point and step arithmetic.
    assign n_angle = 20'(r_a0) + 20'(signed'({2'b00, r_q}));
    assign n_rsum  = {1'b0, r_r} + {1'b0, r_rs};

    // Phase of the reduced angle: the high product and the low term are registered, then the reciprocal term is added.
    assign n_ph_hi  = 33'(r_m[16:0]) * 33'(PHASE_MUL_HI);
    assign n_ph_x   = 22'(r_m[16:0]) * 22'(PHASE_MUL_LO);
    assign n_ph_rec = 43'(r_ph_x) * 43'(PHASE_RECIP);
    assign n_phase  = r_ph_hi + 32'(n_ph_rec >> PHASE_RECIP_SHIFT);

    // CORDIC micro-rotation terms.
    assign n_dx   = r_y >>> r_k;
    assign n_dy   = r_x >>> r_k;
    assign n_atan = 32'(signed'({2'b00, atan_turns(r_k)}));

    // Quadrant fold of the rotated vector.
    always_comb begin
        unique case (r_quad)
            2'd0: begin n_cos = r_x;  n_sin = r_y;  end
            2'd1: begin n_cos = -r_y; n_sin = r_x;  end
            2'd2: begin n_cos = -r_x; n_sin = -r_y; end
            default: begin n_cos = r_y; n_sin = -r_x; end
        endcase
    end

    // Request and point registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx   <= i_center_x;
            r_cy   <= i_center_y;
            r_rad  <= i_radius;
            r_n    <= n_steps;
            if (i_action) begin
                r_a0   <= '0;
                r_span <= 18'(FULL_TURN);
            end else begin
                r_a0   <= 19'(n_lo);
                r_span <= n_span[17:0];
            end
        end
        if (i_cmd.span_done) begin
            r_qs <= div_quo[17:0];
            r_rs <= div_rem;
            r_q  <= '0;
            r_r  <= '0;
            r_i  <= '0;
        end
        if (i_cmd.advance) begin
            r_i <= r_i + 1'b1;
            if (n_rsum >= {1'b0, r_n}) begin
                r_r <= SEG_W'(n_rsum - {1'b0, r_n});
                r_q <= r_q + r_qs + 18'd1;
            end else begin
                r_r <= n_rsum[SEG_W-1:0];
                r_q <= r_q + r_qs;
            end
        end
        // Wrap the angle into one turn, in either direction.
        if (i_cmd.angle) begin
            r_m <= n_angle[19] ? n_angle + 20'sd92160 : n_angle;
        end else if (i_cmd.reduce) begin
            r_m <= r_m[19] ? r_m + 20'sd92160 : r_m - 20'sd92160;
        end
        if (i_cmd.phase_div) begin
            r_ph_hi <= n_ph_hi[31:0];
            r_ph_x  <= n_ph_x[20:0];
        end
        if (i_cmd.cordic_init) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= 32'(signed'({2'b00, n_phase[29:0]}));
            r_quad <= n_phase[31:30];
            r_k    <= '0;
        end else if (i_cmd.cordic_step) begin
            if (!r_z[31]) begin
                r_x <= r_x - n_dx;
                r_y <= r_y + n_dy;
                r_z <= r_z - n_atan;
            end else begin
                r_x <= r_x + n_dx;
                r_y <= r_y - n_dy;
                r_z <= r_z + n_atan;
            end
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.mul_x) begin
            r_prod <= r_rad * signed'(n_cos[31:0]);
        end else if (i_cmd.mul_y) begin
            r_px   <= place_coord(r_cx, r_prod);
            r_prod <= r_rad * signed'(n_sin[31:0]);
        end
        if (i_cmd.fin) begin
            r_py <= place_coord(r_cy, r_prod);
        end
    end

    // Output register: holds a word while the next point is worked on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ox    <= r_px;
            r_oy    <= r_py;
            r_olast <= (r_i == r_n);
        end
    end

    // Status back to the controller.
    always_comb begin
        o_status.nonpos      = (i_radius <= 32'sd0);
        o_status.div_busy    = div_busy;
        o_status.m_ok        = !r_m[19] && (r_m < 20'sd92160);
        o_status.cordic_done = (r_k == 5'(CORDIC_STEPS));
        o_status.last        = (r_i == r_n);
        o_status.out_free    = !r_ovalid || i_out_ready;
    end

    assign o_valid   = r_ovalid;
    assign o_point_x = r_ox;
    assign o_point_y = r_oy;
    assign o_last    = r_olast;

endmodule

`default_nettype wire
